>>> rtl/csra_pkg.sv
// Package for the contiguous slot run allocator.
// Holds command codes, field widths and the map write struct; no dependencies.
package csra_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int LEN_W     = 6;
	localparam int START_W   = 5;
	// start + length tops out at 31 + 63, so 7 bits hold any pointer value
	localparam int PTR_W     = 7;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic en;
		logic data;
	} map_wr_t;

endpackage

>>> rtl/csra_map.sv
// Free map register file for the slot run allocator: one bit per slot.
// One bit written and one bit read per cycle. Depends on csra_pkg.
module csra_map import csra_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  map_wr_t       wr,
	input  logic [IW-1:0] widx,
	input  logic [IW-1:0] ridx,
	output logic          rbit
);

	logic [SLOTS-1:0] map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '1;
		end else if (wr.en) begin
			map_q[widx] <= wr.data;
		end
	end

	assign rbit = map_q[ridx];

endmodule

>>> rtl/contiguous_slot_run_allocator.sv
// Contiguous slot run allocator: first-fit search over a free map of slots.
// An allocate item scans the map one slot per cycle from slot 0, counting
// consecutive free slots; on a fit it goes back to the run's first slot and
// clears the run one slot per cycle. An allocate scans at most SLOTS slots and
// marks run_length; a free sets min(run_length, SLOTS - start_slot) slots free.
// The single-bit map port sets this one-slot pace. One item is in work
// at a time; the result register lets the next item in while a result waits.
module contiguous_slot_run_allocator import csra_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [LEN_W-1:0]   run_length,
	input  logic [START_W-1:0] start_slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               granted,
	output logic [START_W-1:0] slot
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PTR_W-1:0] SLOTS_P = PTR_W'(SLOTS);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   run_q;
	logic [LEN_W-1:0]   cnt_q;
	logic               res_grant_q;
	logic [START_W-1:0] res_slot_q;
	logic               out_valid_q;
	logic               granted_q;
	logic [START_W-1:0] slot_q;

	map_wr_t            wr;
	logic               rbit;
	logic [LEN_W-1:0]   run_next;
	logic [PTR_W-1:0]   first;
	logic               in_acc;
	logic               out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign run_next = rbit ? LEN_W'(run_q + LEN_W'(1)) : '0;
	assign first    = PTR_W'(ptr_q + PTR_W'(1) - PTR_W'(len_q));

	always_comb begin
		wr.en   = 1'b0;
		wr.data = 1'b0;
		case (state_q)
			ST_MARK: begin
				wr.en   = 1'b1;
				wr.data = 1'b0;
			end
			ST_FREE: begin
				wr.en   = (cnt_q != '0) && (ptr_q < SLOTS_P);
				wr.data = 1'b1;
			end
			default: begin
				wr.en   = 1'b0;
				wr.data = 1'b0;
			end
		endcase
	end

	csra_map #(.SLOTS(SLOTS), .IW(IW)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.widx   (ptr_q[IW-1:0]),
		.ridx   (ptr_q[IW-1:0]),
		.rbit   (rbit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			len_q       <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			res_grant_q <= 1'b0;
			res_slot_q  <= '0;
			granted_q   <= 1'b0;
			slot_q      <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						len_q       <= run_length;
						cnt_q       <= run_length;
						run_q       <= '0;
						res_grant_q <= 1'b0;
						res_slot_q  <= '0;
						if (cmd == CMD_FREE) begin
							ptr_q   <= PTR_W'(start_slot);
							state_q <= ST_FREE;
						end else if (run_length == '0 ||
							PTR_W'(run_length) > SLOTS_P) begin
							state_q <= ST_DONE;
						end else begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					run_q <= run_next;
					if (run_next == len_q) begin
						ptr_q       <= first;
						res_grant_q <= 1'b1;
						res_slot_q  <= first[START_W-1:0];
						state_q     <= ST_MARK;
					end else if (ptr_q == LAST_P) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= PTR_W'(ptr_q + PTR_W'(1));
					end
				end
				ST_MARK: begin
					ptr_q <= PTR_W'(ptr_q + PTR_W'(1));
					cnt_q <= LEN_W'(cnt_q - LEN_W'(1));
					if (cnt_q == LEN_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_FREE: begin
					if (cnt_q == '0 || ptr_q >= SLOTS_P) begin
						res_grant_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						ptr_q <= PTR_W'(ptr_q + PTR_W'(1));
						cnt_q <= LEN_W'(cnt_q - LEN_W'(1));
					end
				end
				ST_DONE: begin
					// hold the result until the output register can take it
					if (out_free) begin
						granted_q   <= res_grant_q;
						slot_q      <= res_slot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;
	assign slot      = slot_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_MARK) |-> (ptr_q < SLOTS_P))
		else $error("map pointer out of range during scan or mark");

	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (cnt_q != '0))
		else $error("mark pass entered with zero remaining slots");

	a_no_grant_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !granted_q) |-> (slot_q == '0))
		else $error("refused item carries a nonzero slot");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_MARK || state_q == ST_FREE))
		else $error("map written outside mark or free pass");

	a_scan_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (run_q < len_q))
		else $error("run count reached length without a grant");

endmodule
